FILE: rtl/core/efws_pkg.sv
`default_nettype none
package efws_pkg;

	localparam int DUR_W = 32;
	localparam int TIME_W = 64;
	localparam int WIDX_W = 4;
	localparam int ACT_W = 5;
	localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

	typedef struct packed {
		logic start;
		logic issue;
		logic commit;
	} efws_cmd_t;

	typedef struct packed {
		logic last_issue;
	} efws_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/efws_ifs.sv
`default_nettype none
interface efws_job_if;
	logic valid;
	logic ready;
	logic [efws_pkg::DUR_W-1:0] job_duration;
	modport source(output valid, output job_duration, input ready);
	modport sink(input valid, input job_duration, output ready);
endinterface

interface efws_res_if;
	logic valid;
	logic ready;
	logic [efws_pkg::WIDX_W-1:0] worker_index;
	logic [efws_pkg::TIME_W-1:0] start_time;
	modport source(output valid, output worker_index, output start_time, input ready);
	modport sink(input valid, input worker_index, input start_time, output ready);
endinterface

interface efws_cfg_if;
	logic valid;
	logic ready;
	logic [efws_pkg::ACT_W-1:0] active_workers;
	modport source(output valid, output active_workers, input ready);
	modport sink(input valid, input active_workers, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/earliest_free_worker_scheduler_core.sv
// Earliest-free worker scheduler.
// job (sink): one job duration per transaction. result (source): the chosen
// worker and the job's start time. cfg (sink): active_workers, always ready;
// write it only while no job is in flight.
// Each job scans the next-free times of the active workers from a memory,
// one entry per cycle through a registered read port, keeping the smallest
// (lowest index on ties). A job moves from an accept state through a read
// state, with one read per worker of the clamped count, then a compare drain
// and an update state, which loads the output register and raises result valid.
// The winner's free time advances by the duration, saturating at all ones.
// The result sits in an output register, so the next job is accepted while
// it waits; if the receiver still stalls when that job finishes, the
// update cycle holds until the register is free.
// Reset clears all free times to zero (per-entry written bits) and sets
// active_workers to 16; no clearing sweep is needed.
`default_nettype none
module earliest_free_worker_scheduler_core #(
	parameter int MAX_WORKERS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	efws_job_if.sink   job,
	efws_res_if.source result,
	efws_cfg_if.sink   cfg
);

	efws_pkg::efws_cmd_t cmd;
	efws_pkg::efws_sts_t sts;

	assign cfg.ready = 1'b1;

	efws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job.valid),
		.job_ready (job.ready),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	efws_dp #(
		.MAX_WORKERS (MAX_WORKERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg.valid),
		.cfg_data     (cfg.active_workers),
		.job_duration (job.job_duration),
		.cmd          (cmd),
		.sts          (sts),
		.worker_index (result.worker_index),
		.start_time   (result.start_time)
	);

`ifndef SYNTHESIS
	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !result.valid)
		else $error("result overwritten while pending");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> result.valid)
		else $error("result not presented after update");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && sts.last_issue |=> !cmd.issue)
		else $error("scan ran past last worker");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !job.ready)
		else $error("job accepted during scan");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/efws_ctrl.sv
`default_nettype none
module efws_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	output logic                   job_ready,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output efws_pkg::efws_cmd_t    cmd,
	input  wire efws_pkg::efws_sts_t sts
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_full_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		job_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					cmd.start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			// last read lands in the compare stage
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				// wait for the output slot before updating the worker
				if (!out_full_q) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_full_q <= 1'b1;
			end else if (res_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_full_q;

endmodule
`default_nettype wire

FILE: rtl/core/efws_dp.sv
`default_nettype none
module efws_dp #(
	parameter int MAX_WORKERS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [efws_pkg::ACT_W-1:0]      cfg_data,
	input  wire logic [efws_pkg::DUR_W-1:0]      job_duration,
	input  wire efws_pkg::efws_cmd_t             cmd,
	output efws_pkg::efws_sts_t                  sts,
	output logic [efws_pkg::WIDX_W-1:0]          worker_index,
	output logic [efws_pkg::TIME_W-1:0]          start_time
);

	localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int CNT_W = $clog2(MAX_WORKERS + 1);
	localparam int CMP_W = (CNT_W > efws_pkg::ACT_W) ? CNT_W : efws_pkg::ACT_W;
	localparam int TW = efws_pkg::TIME_W;

	logic [efws_pkg::ACT_W-1:0] active_q;
	logic [efws_pkg::DUR_W-1:0] dur_q;
	logic [IDX_W-1:0]           ptr_q;
	logic [TW-1:0]              rd_data_s1;
	logic [IDX_W-1:0]           rd_idx_s1;
	logic                       rd_vld_s1;
	logic [TW-1:0]              best_time_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic [TW-1:0]              free_mem [MAX_WORKERS];
	logic [MAX_WORKERS-1:0]     written_q;

	logic [CMP_W-1:0] act_ext;
	logic [CMP_W-1:0] n_eff;
	logic [CMP_W-1:0] last_w;
	logic [IDX_W-1:0] last_idx;
	logic [TW:0]      sum;
	logic [TW-1:0]    new_time;

	// clamp the worker count to 1..MAX_WORKERS
	always_comb begin
		act_ext = CMP_W'(active_q);
		if (act_ext == '0) begin
			n_eff = CMP_W'(1);
		end else if (act_ext > CMP_W'(MAX_WORKERS)) begin
			n_eff = CMP_W'(MAX_WORKERS);
		end else begin
			n_eff = act_ext;
		end
		last_w = n_eff - CMP_W'(1);
		last_idx = last_w[IDX_W-1:0];
	end

	assign sts.last_issue = (ptr_q == last_idx);

	// saturating add of the duration
	assign sum = {1'b0, best_time_q} + {{(TW + 1 - efws_pkg::DUR_W){1'b0}}, dur_q};
	assign new_time = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= efws_pkg::ACT_RESET;
			rd_vld_s1 <= 1'b0;
			written_q <= '0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			rd_vld_s1 <= cmd.issue;
			if (cmd.commit) begin
				written_q[best_idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dur_q <= job_duration;
			ptr_q <= '0;
		end else if (cmd.issue) begin
			ptr_q <= ptr_q + IDX_W'(1);
		end
		// entries never written read as zero
		rd_data_s1 <= written_q[ptr_q] ? free_mem[ptr_q] : '0;
		rd_idx_s1 <= ptr_q;
		if (rd_vld_s1) begin
			if ((rd_idx_s1 == '0) || (rd_data_s1 < best_time_q)) begin
				best_time_q <= rd_data_s1;
				best_idx_q <= rd_idx_s1;
			end
		end
		if (cmd.commit) begin
			free_mem[best_idx_q] <= new_time;
			worker_index <= efws_pkg::WIDX_W'(best_idx_q);
			start_time <= best_time_q;
		end
	end

endmodule
`default_nettype wire

FILE: bench/earliest_free_worker_scheduler_core_tb.sv
`default_nettype none
module earliest_free_worker_scheduler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DUR_W = efws_pkg::DUR_W;
	localparam int TIME_W = efws_pkg::TIME_W;
	localparam int WIDX_W = efws_pkg::WIDX_W;
	localparam int ACT_W = efws_pkg::ACT_W;

	localparam int WORKERS = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int SEGMENTS = 5;
	localparam int JOBS_PER_SEGMENT = 100;

	typedef enum logic {ROW_CONFIG, ROW_JOB} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [DUR_W-1:0] value;
		logic typed;
		logic [WIDX_W-1:0] worker;
		logic [TIME_W-1:0] start;
	} directed_step_t;

	typedef struct {
		logic [WIDX_W-1:0] worker;
		logic [TIME_W-1:0] start;
	} assignment_t;

	// after reset all workers are free at zero and sixteen are active
	localparam int N_DIRECTED = 24;
	localparam directed_step_t DIRECTED_STEPS [N_DIRECTED] = '{
		'{ROW_JOB,    32'd5,          1'b1, 4'd0, 64'd0},
		'{ROW_JOB,    32'd0,          1'b1, 4'd1, 64'd0},
		'{ROW_JOB,    32'd0,          1'b1, 4'd1, 64'd0},
		'{ROW_JOB,    32'hFFFF_FFFF,  1'b1, 4'd1, 64'd0},
		'{ROW_CONFIG, 32'd1,          1'b0, 4'd0, 64'd0},
		'{ROW_JOB,    32'd7,          1'b1, 4'd0, 64'd5},
		'{ROW_JOB,    32'hFFFF_FFFF,  1'b1, 4'd0, 64'd12},
		// zero workers behaves as one
		'{ROW_CONFIG, 32'd0,          1'b0, 4'd0, 64'd0},
		'{ROW_JOB,    32'd3,          1'b1, 4'd0, 64'h1_0000_000B},
		// counts above sixteen clamp to sixteen
		'{ROW_CONFIG, 32'd31,         1'b0, 4'd0, 64'd0},
		'{ROW_JOB,    32'd1,          1'b1, 4'd2, 64'd0},
		'{ROW_CONFIG, 32'd17,         1'b0, 4'd0, 64'd0},
		'{ROW_JOB,    32'd1,          1'b1, 4'd3, 64'd0},
		// lowered count hides the idle workers but keeps their times
		'{ROW_CONFIG, 32'd2,          1'b0, 4'd0, 64'd0},
		'{ROW_JOB,    32'd0,          1'b1, 4'd1, 64'hFFFF_FFFF},
		'{ROW_JOB,    32'h8000_0000,  1'b1, 4'd1, 64'hFFFF_FFFF},
		'{ROW_JOB,    32'd1,          1'b1, 4'd0, 64'h1_0000_000E},
		'{ROW_CONFIG, 32'd16,         1'b0, 4'd0, 64'd0},
		'{ROW_JOB,    32'd0,          1'b1, 4'd4, 64'd0},
		'{ROW_JOB,    32'h5555_5555,  1'b0, 4'd0, 64'd0},
		'{ROW_JOB,    32'hAAAA_AAAA,  1'b0, 4'd0, 64'd0},
		'{ROW_CONFIG, 32'd15,         1'b0, 4'd0, 64'd0},
		'{ROW_JOB,    32'd9,          1'b0, 4'd0, 64'd0},
		'{ROW_JOB,    32'd0,          1'b0, 4'd0, 64'd0}
	};

	logic clk;
	logic arst_n;

	efws_job_if job_ch();
	efws_res_if res_ch();
	efws_cfg_if cfg_ch();

	earliest_free_worker_scheduler_core #(
		.MAX_WORKERS(WORKERS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.job(job_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	logic [TIME_W-1:0] free_at [WORKERS];
	logic [ACT_W-1:0] worker_limit;
	assignment_t pending_assignments [$];
	int error_count = 0;
	int src_idle_pct = 25;
	int snk_idle_pct = 62;
	int hold_requests = 0;
	int hold_served = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic assignment_t assign_earliest_worker(input logic [DUR_W-1:0] dur);
		int count;
		int best;
		logic [TIME_W:0] sum;
		assignment_t a;
		count = (worker_limit == 0) ? 1 : ((worker_limit > WORKERS) ? WORKERS : int'(worker_limit));
		best = 0;
		for (int w = 1; w < count; w++)
			if (free_at[w] < free_at[best])
				best = w;
		a.worker = best[WIDX_W-1:0];
		a.start = free_at[best];
		sum = {1'b0, free_at[best]} + {{(TIME_W-DUR_W+1){1'b0}}, dur};
		free_at[best] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		return a;
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_job(input logic [DUR_W-1:0] dur, input logic typed,
			input logic [WIDX_W-1:0] worker, input logic [TIME_W-1:0] start);
		assignment_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			job_ch.valid = 1'b0;
			@(negedge clk);
		end
		job_ch.valid = 1'b1;
		job_ch.job_duration = dur;
		@(posedge clk);
		while (!job_ch.ready)
			@(posedge clk);
		predicted = assign_earliest_worker(dur);
		if (typed) begin
			predicted.worker = worker;
			predicted.start = start;
		end
		pending_assignments.push_back(predicted);
		@(negedge clk);
	endtask

	task automatic drain_jobs();
		job_ch.valid = 1'b0;
		while (pending_assignments.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_active_workers(input logic [ACT_W-1:0] count);
		drain_jobs();
		cfg_ch.valid = 1'b1;
		cfg_ch.active_workers = count;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		worker_limit = count;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic [DUR_W-1:0] random_duration();
		case ($urandom_range(7))
			0, 1: return '0;
			2, 3: return DUR_W'($urandom_range(15));
			4: return '1;
			default: return DUR_W'($urandom);
		endcase
	endfunction

	function automatic logic [ACT_W-1:0] random_worker_count();
		case ($urandom_range(9))
			0: return 5'd0;
			1: return 5'd1;
			2: return 5'd2;
			3: return 5'd16;
			4: return 5'd17;
			5: return 5'd31;
			6: return 5'd15;
			default: return ACT_W'($urandom_range(31));
		endcase
	endfunction

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_served++;
			end else begin
				res_ch.ready = ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		assignment_t exp_a;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_assignments.size() == 0) begin
				$error("unexpected result transaction: worker_index %0d start_time %0h",
					res_ch.worker_index, res_ch.start_time);
				error_count++;
			end else begin
				exp_a = pending_assignments.pop_front();
				if (res_ch.worker_index !== exp_a.worker) begin
					$error("worker_index: expected %0d, got %0d", exp_a.worker,
						res_ch.worker_index);
					error_count++;
				end
				if (res_ch.start_time !== exp_a.start) begin
					$error("start_time: expected %0h, got %0h", exp_a.start,
						res_ch.start_time);
					error_count++;
				end
			end
		end
	end

	initial begin
		#4ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		job_ch.valid = 1'b0;
		job_ch.job_duration = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.active_workers = '0;
		worker_limit = efws_pkg::ACT_RESET;
		for (int w = 0; w < WORKERS; w++)
			free_at[w] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED_STEPS[i]) begin
			if (DIRECTED_STEPS[i].kind == ROW_CONFIG)
				set_active_workers(DIRECTED_STEPS[i].value[ACT_W-1:0]);
			else
				send_job(DIRECTED_STEPS[i].value, DIRECTED_STEPS[i].typed,
					DIRECTED_STEPS[i].worker, DIRECTED_STEPS[i].start);
		end

		// receiver-heavy idling, then sender-heavy, then none
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 25;
					snk_idle_pct = 62;
				end
				1: begin
					src_idle_pct = 62;
					snk_idle_pct = 25;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				set_active_workers(random_worker_count());
				// long receiver stall with the sender pushing until the block backs up
				if (phase == 2 && seg == 0)
					hold_requests++;
				for (int j = 0; j < JOBS_PER_SEGMENT; j++)
					send_job(random_duration(), 1'b0, '0, '0);
			end
		end

		job_ch.valid = 1'b0;
		while (pending_assignments.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
